// ===== hdl/cwa_pkg.sv =====
// shared types, constants and codes for the weighted chi-squared accumulator
// no dependencies; every other file but cwa_if imports this package
package cwa_pkg;

   // frame size limit and counter saturation
   localparam int MAX_FRAME_PIXELS = 4194304;
   localparam int COUNT_W = 23;
   localparam int CHI_W = 63;
   localparam logic [COUNT_W-1:0] COUNT_CAP =
      (MAX_FRAME_PIXELS < (2**COUNT_W - 1)) ? COUNT_W'(MAX_FRAME_PIXELS)
                                            : {COUNT_W{1'b1}};
   localparam logic [CHI_W-1:0] CHI_MAX = {CHI_W{1'b1}};
   localparam logic [31:0] WEIGHT_MAX = 32'hFFFF_FFFF;

   // request queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   // shared restoring divider
   localparam int DIV_NUM_W = 65;
   localparam int DIV_DEN_W = 48;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
   localparam logic [DIV_NUM_W-1:0] DIV_ONE = {1'b1, {(DIV_NUM_W-1){1'b0}}};

   // csr map
   localparam int ADDR_W = 3;
   localparam logic REG_GAIN = 1'b0;
   localparam logic REG_SAT  = 1'b1;

   // request class decided at the front
   typedef enum logic [1:0] {
      CLS_SAT,
      CLS_GAIN,
      CLS_PLAIN
   } cwa_class_type;

   typedef struct packed {
      cwa_class_type cls;
      logic [30:0]   pix;
      logic [31:0]   bvar;
      logic [31:0]   resid;
      logic          last;
   } cwa_entry_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } cwa_div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quo;
   } cwa_div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_GAIN,
      ST_CHECK_D,
      ST_DIV_INV,
      ST_SQRT,
      ST_MUL_P,
      ST_MUL_LL,
      ST_MUL_HL,
      ST_MUL_HH,
      ST_ACCUM
   } cwa_state_type;

endpackage

// ===== hdl/cwa_if.sv =====
// request and result channel interfaces
// no dependencies
interface cwa_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_value;
   logic [31:0] model_value;
   logic [31:0] background_variance;
   logic        frame_end;
   modport source (output valid, pixel_value, model_value, background_variance, frame_end,
                   input ready);
   modport sink (input valid, pixel_value, model_value, background_variance, frame_end,
                 output ready);
endinterface

interface cwa_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_weight;
   logic [62:0] chi_squared_sum;
   logic [22:0] good_pixel_count;
   logic        frame_done;
   modport source (output valid, pixel_weight, chi_squared_sum, good_pixel_count, frame_done,
                   input ready);
   modport sink (input valid, pixel_weight, chi_squared_sum, good_pixel_count, frame_done,
                 output ready);
endinterface

// ===== hdl/weighted_chi_squared_pixel_accumulator.sv =====
// Weighted chi-squared pixel accumulator. Each request is one pixel (signed Q16.16 value
// and model, unsigned Q16.16 variance); each gives one result with the pixel's inverse-sigma
// weight (Q8.24) and the running weighted squared residual (Q39.24) and good-pixel count,
// which clear after the pixel marked frame_end. Pixels are processed one at a time by a
// sequencer behind a two-entry request queue. A saturated pixel skips the divisions and
// the square root, as does a pixel whose denominator is at most one LSB; an ordinary
// pixel takes one division and the 32-step square root, and a pixel with a gain term
// takes a further division first. The bit-serial divider forms 65 quotient bits. The
// result leaves from an output register loaded in the last sequencer state, and a
// stalled result holds the sequencer there.
// Configuration: gain at byte 0, saturation level at byte 4, written over the APB port.
// depends on cwa_pkg, cwa_if, cwa_front, cwa_queue, cwa_back
module weighted_chi_squared_pixel_accumulator (
   input  logic                       clock,
   input  logic                       reset,
   cwa_req_if.sink                    req_chan,
   cwa_rsp_if.source                  rsp_chan,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [cwa_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);
   import cwa_pkg::*;

   logic [31:0]   gain_ff;
   logic [30:0]   sat_ff;
   logic          push;
   logic          pop;
   logic          q_full;
   logic          q_empty;
   cwa_entry_type push_entry;
   cwa_entry_type head;
   logic          wr_en;

   // csr write and read
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= '0;
         sat_ff  <= '0;
      end else if (wr_en) begin
         unique case (paddr[2])
            REG_GAIN: gain_ff <= pwdata;
            REG_SAT:  sat_ff  <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_GAIN: prdata = gain_ff;
         REG_SAT:  prdata = {1'b0, sat_ff};
         default:  prdata = '0;
      endcase
   end

   cwa_front u_cwa_front (
      .req_chan  (req_chan),
      .gain      (gain_ff),
      .sat_level (sat_ff),
      .q_full    (q_full),
      .push      (push),
      .entry     (push_entry)
   );

   cwa_queue u_cwa_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (q_full),
      .empty      (q_empty)
   );

   cwa_back u_cwa_back (
      .clock    (clock),
      .reset    (reset),
      .gain     (gain_ff),
      .head     (head),
      .q_empty  (q_empty),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== hdl/cwa_front.sv =====
// front end: accepts requests, classifies the weight path, forms |residual|
// depends on cwa_pkg and cwa_req_if
module cwa_front (
   cwa_req_if.sink          req_chan,
   input  logic [31:0]      gain,
   input  logic [30:0]      sat_level,
   input  logic             q_full,
   output logic             push,
   output cwa_pkg::cwa_entry_type entry
);
   import cwa_pkg::*;

   logic        sat_hit;
   logic [32:0] diff;
   logic [32:0] mag;

   // handshake into the queue
   assign req_chan.ready = !q_full;
   assign push = req_chan.valid && !q_full;

   // saturation check and weight path
   assign sat_hit = (sat_level != 31'd0) &&
                    ($signed(req_chan.pixel_value) > $signed({1'b0, sat_level}));

   // exact residual magnitude
   assign diff = {req_chan.pixel_value[31], req_chan.pixel_value} -
                 {req_chan.model_value[31], req_chan.model_value};
   assign mag = diff[32] ? (~diff + 33'd1) : diff;

   always_comb begin
      priority if (sat_hit) begin
         entry.cls = CLS_SAT;
      end else if ((gain != 32'd0) && ($signed(req_chan.pixel_value) > 32'sd0)) begin
         entry.cls = CLS_GAIN;
      end else begin
         entry.cls = CLS_PLAIN;
      end
      entry.pix   = req_chan.pixel_value[30:0];
      entry.bvar  = req_chan.background_variance;
      entry.resid = mag[31:0];
      entry.last  = req_chan.frame_end;
   end

endmodule

// ===== hdl/cwa_queue.sv =====
// short request queue between front and back
// depends on cwa_pkg
module cwa_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  cwa_pkg::cwa_entry_type push_entry,
   input  logic                   pop,
   output cwa_pkg::cwa_entry_type head,
   output logic                   full,
   output logic                   empty
);
   import cwa_pkg::*;

   cwa_entry_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]         count_ff, count_in;
   logic                    do_push, do_pop;

   assign full    = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   // pointer and fill updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== hdl/cwa_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
// depends on cwa_pkg
module cwa_div (
   input  logic                    clock,
   input  logic                    reset,
   input  cwa_pkg::cwa_div_req_type div_req,
   output cwa_pkg::cwa_div_rsp_type div_rsp
);
   import cwa_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_DEN_W:0]   shifted;
   logic [DIV_DEN_W:0]   diff;
   logic                 ge;
   logic                 last_step;

   // one restoring step
   assign shifted   = {rem_ff, num_ff[DIV_NUM_W-1]};
   assign ge        = shifted >= {1'b0, den_ff};
   assign diff      = shifted - {1'b0, den_ff};
   assign rem_in    = ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
   assign num_in    = {num_ff[DIV_NUM_W-2:0], ge};
   assign last_step = busy_ff && (cnt_ff == DIV_CNT_W'(DIV_NUM_W-1));

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = num_ff;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= last_step;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            busy_ff <= !last_step;
            cnt_ff  <= cnt_ff + 1'b1;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         num_ff <= div_req.num;
         den_ff <= div_req.den;
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

endmodule

// ===== hdl/cwa_back.sv =====
// back end: weight via divider and square root, squared term, running sums
// depends on cwa_pkg, cwa_rsp_if and cwa_div
module cwa_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [31:0]            gain,
   input  cwa_pkg::cwa_entry_type head,
   input  logic                   q_empty,
   output logic                   pop,
   cwa_rsp_if.source              rsp_chan
);
   import cwa_pkg::*;

   cwa_state_type   state_ff, state_in;
   cwa_div_req_type div_req;
   cwa_div_rsp_type div_rsp;

   cwa_entry_type   entry_ff;
   logic [47:0]     d_ff;
   logic [63:0]     x_ff, x_in;
   logic [63:0]     res_ff, res_in;
   logic [63:0]     bit_ff;
   logic [63:0]     trial;
   logic            take;
   logic [31:0]     w_ff;
   logic [63:0]     p_ff;
   logic [127:0]    sq_ff;
   logic [31:0]     mul_a, mul_b;
   logic [63:0]     prod;
   logic [62:0]     term;
   logic [63:0]     sum;
   logic [62:0]     chi_new;
   logic [22:0]     cnt_new;
   logic            out_free;

   logic [62:0]     chi_ff;
   logic [22:0]     cnt_ff;
   logic            rsp_valid_ff;
   logic [31:0]     rsp_weight_ff;
   logic [62:0]     rsp_chi_ff;
   logic [22:0]     rsp_cnt_ff;
   logic            rsp_done_ff;

   cwa_div u_cwa_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // result register drives the channel
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.pixel_weight     = rsp_weight_ff;
   assign rsp_chan.chi_squared_sum  = rsp_chi_ff;
   assign rsp_chan.good_pixel_count = rsp_cnt_ff;
   assign rsp_chan.frame_done       = rsp_done_ff;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // square root digit step
   assign trial  = res_ff + bit_ff;
   assign take   = x_ff >= trial;
   assign x_in   = take ? (x_ff - trial) : x_ff;
   assign res_in = take ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);

   // shared 32x32 multiplier
   assign prod = mul_a * mul_b;

   // term, saturating sum and count
   assign term    = (sq_ff[127:119] != 9'd0) ? CHI_MAX : sq_ff[118:56];
   assign sum     = {1'b0, chi_ff} + {1'b0, term};
   assign chi_new = sum[63] ? CHI_MAX : sum[62:0];
   assign cnt_new = ((w_ff != 32'd0) && (cnt_ff < COUNT_CAP)) ? cnt_ff + 1'b1 : cnt_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               unique case (head.cls)
                  CLS_GAIN: state_in = ST_DIV_GAIN;
                  CLS_SAT:  state_in = ST_MUL_P;
                  default:  state_in = ST_CHECK_D;
               endcase
            end
         end
         ST_DIV_GAIN: if (div_rsp.done) state_in = ST_CHECK_D;
         ST_CHECK_D:  state_in = (d_ff > 48'd1) ? ST_DIV_INV : ST_MUL_P;
         ST_DIV_INV:  if (div_rsp.done) state_in = ST_SQRT;
         ST_SQRT:     if (bit_ff[0]) state_in = ST_MUL_P;
         ST_MUL_P:    state_in = ST_MUL_LL;
         ST_MUL_LL:   state_in = ST_MUL_HL;
         ST_MUL_HL:   state_in = ST_MUL_HH;
         ST_MUL_HH:   state_in = ST_ACCUM;
         ST_ACCUM:    if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs: queue pop, divider start, multiplier operands
   always_comb begin
      pop           = 1'b0;
      div_req.start = 1'b0;
      div_req.num   = DIV_ONE;
      div_req.den   = d_ff;
      mul_a         = p_ff[31:0];
      mul_b         = p_ff[31:0];
      unique case (state_ff)
         ST_IDLE: begin
            pop           = !q_empty;
            div_req.start = !q_empty && (head.cls == CLS_GAIN);
            div_req.num   = {18'd0, head.pix, 16'd0};
            div_req.den   = {16'd0, gain};
         end
         ST_CHECK_D: div_req.start = d_ff > 48'd1;
         ST_MUL_P: begin
            mul_a = entry_ff.resid;
            mul_b = w_ff;
         end
         ST_MUL_HL: mul_a = p_ff[63:32];
         ST_MUL_HH: begin
            mul_a = p_ff[63:32];
            mul_b = p_ff[63:32];
         end
         default: ;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         chi_ff       <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == ST_ACCUM) && out_free) begin
            rsp_valid_ff <= 1'b1;
            chi_ff       <= entry_ff.last ? '0 : chi_new;
            cnt_ff       <= entry_ff.last ? '0 : cnt_new;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            entry_ff <= head;
            d_ff     <= {16'd0, head.bvar};
            w_ff     <= 32'd0;
         end
         ST_DIV_GAIN: if (div_rsp.done) d_ff <= d_ff + div_rsp.quo[47:0];
         ST_CHECK_D:  w_ff <= WEIGHT_MAX;
         ST_DIV_INV: begin
            x_ff   <= div_rsp.quo[63:0];
            res_ff <= '0;
            bit_ff <= 64'd1 << 62;
         end
         ST_SQRT: begin
            x_ff   <= x_in;
            res_ff <= res_in;
            bit_ff <= bit_ff >> 2;
            w_ff   <= res_in[31:0];
         end
         ST_MUL_P:  p_ff  <= prod;
         ST_MUL_LL: sq_ff <= {64'd0, prod};
         ST_MUL_HL: sq_ff <= sq_ff + ({64'd0, prod} << 33);
         ST_MUL_HH: sq_ff <= sq_ff + {prod, 64'd0};
         ST_ACCUM: begin
            if (out_free) begin
               rsp_weight_ff <= w_ff;
               rsp_chi_ff    <= chi_new;
               rsp_cnt_ff    <= cnt_new;
               rsp_done_ff   <= entry_ff.last;
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== hdl/cwa_checker.sv =====
// port-level checks on the result channel of the accumulator
// depends on cwa_pkg; bound to weighted_chi_squared_pixel_accumulator
module cwa_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] pixel_weight,
   input logic [62:0] chi_squared_sum,
   input logic [22:0] good_pixel_count,
   input logic        frame_done
);
   import cwa_pkg::*;

   // no result right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result stays offered
   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(pixel_weight) && $stable(chi_squared_sum) &&
      $stable(good_pixel_count) && $stable(frame_done))
      else $error("result payload changed while stalled");

   // good pixel count never passes its cap
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> good_pixel_count <= COUNT_CAP)
      else $error("good pixel count above cap");

endmodule

bind weighted_chi_squared_pixel_accumulator cwa_checker u_cwa_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .pixel_weight     (rsp_chan.pixel_weight),
   .chi_squared_sum  (rsp_chan.chi_squared_sum),
   .good_pixel_count (rsp_chan.good_pixel_count),
   .frame_done       (rsp_chan.frame_done)
);
